// ===== rtl/adfp_pkg.sv =====
// shared constants, types and helpers of the ascii decimal to fixed-point parser
`timescale 1ns / 1ps
package adfp_pkg;

  localparam int FRAC_BITS_DEF       = 16;
  localparam int MAX_FRAC_DIGITS_DEF = 6;
  localparam int INT_BITS_DEF        = 21;
  localparam int QUEUE_DEPTH         = 2;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic REG_MAX_LIMIT = 1'b0;
  localparam logic REG_MIN_LIMIT = 1'b1;

  // x / 10 == (x * RECIP10) >> RECIP10_SHIFT for any 32-bit x
  localparam logic [31:0] RECIP10       = 32'hCCCCCCCD;
  localparam int          RECIP10_SHIFT = 35;

  typedef struct packed {
    logic fail;
    logic negative;
  } num_flags_t;

  function automatic logic is_space(input logic [7:0] c);
    return c inside {[CH_TAB:CH_CR], CH_SPACE};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic logic [31:0] pow10(input logic [3:0] n);
    logic [31:0] p;
    case (n)
      4'd0:    p = 32'd1;
      4'd1:    p = 32'd10;
      4'd2:    p = 32'd100;
      4'd3:    p = 32'd1000;
      4'd4:    p = 32'd10000;
      4'd5:    p = 32'd100000;
      4'd6:    p = 32'd1000000;
      4'd7:    p = 32'd10000000;
      4'd8:    p = 32'd100000000;
      4'd9:    p = 32'd1000000000;
      default: p = 32'd1;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/adfp_queue.sv =====
// small register fifo between the byte front end and the conversion back end
`timescale 1ns / 1ps
module adfp_queue import adfp_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

endmodule

// ===== rtl/adfp_front.sv =====
// byte front end: whitespace, sign, digit and terminator parsing with the integer bound check
`timescale 1ns / 1ps
module adfp_front import adfp_pkg::*; #(
  parameter int INT_BITS        = INT_BITS_DEF,
  parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF,
  localparam int ACC_W          = INT_BITS + 1,
  localparam int FRAC_ACC_W     = $clog2(10 ** MAX_FRAC_DIGITS),
  localparam int CNT_W          = $clog2(MAX_FRAC_DIGITS + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 ch,
  input  logic                       restart,
  input  logic signed [INT_BITS-1:0] max_limit,
  input  logic                       queue_full,
  output logic                       push,
  output num_flags_t                 push_flags,
  output logic [ACC_W-1:0]           push_int,
  output logic [FRAC_ACC_W-1:0]      push_frac,
  output logic [CNT_W-1:0]           push_count
);

  localparam logic [2:0] PH_SKIP   = 3'd0;
  localparam logic [2:0] PH_SIGNED = 3'd1;
  localparam logic [2:0] PH_INT    = 3'd2;
  localparam logic [2:0] PH_DOT    = 3'd3;
  localparam logic [2:0] PH_FRAC   = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  localparam int MUL_W  = ACC_W + 4;
  localparam int FMUL_W = FRAC_ACC_W + 4;
  localparam int PROD_W = INT_BITS + RECIP10_SHIFT;
  localparam logic signed [INT_BITS-1:0] BOUND_TEN = INT_BITS'(10);

  logic [2:0]                 phase;
  logic [2:0]                 phase_next;
  logic                       negative;
  logic                       negative_next;
  logic [ACC_W-1:0]           int_acc;
  logic [ACC_W-1:0]           int_acc_next;
  logic signed [INT_BITS-1:0] bound_div;
  logic signed [INT_BITS-1:0] bound_div_next;
  logic [FRAC_ACC_W-1:0]      frac_acc;
  logic [FRAC_ACC_W-1:0]      frac_acc_next;
  logic [CNT_W-1:0]           frac_count;
  logic [CNT_W-1:0]           frac_count_next;

  logic [2:0]                 ph_eff;
  logic                       neg_eff;
  logic [FRAC_ACC_W-1:0]      facc_eff;
  logic [CNT_W-1:0]           fcnt_eff;
  logic                       first_digit;
  logic [3:0]                 digit;
  logic signed [INT_BITS-1:0] digit_s;
  logic signed [INT_BITS-1:0] bound_src;
  logic                       bound_bad;
  logic [PROD_W-1:0]          bound_prod;
  logic signed [INT_BITS-1:0] bound_quot;
  logic [ACC_W-1:0]           int_base;
  logic [MUL_W-1:0]           int_mul;
  logic [ACC_W-1:0]           int_sat;
  logic [FMUL_W-1:0]          frac_mul;
  logic                       accept;
  logic                       emit;
  logic                       fail;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  // restart clears the number before this byte is looked at
  assign ph_eff   = restart ? PH_SKIP : phase;
  assign neg_eff  = restart ? 1'b0 : negative;
  assign facc_eff = restart ? '0 : frac_acc;
  assign fcnt_eff = restart ? '0 : frac_count;

  assign first_digit = (ph_eff == PH_SKIP) || (ph_eff == PH_SIGNED);
  assign digit       = ch[3:0];
  assign digit_s     = $signed({{(INT_BITS-4){1'b0}}, digit});

  // bound reloads from max_limit at the first integer digit
  assign bound_src  = first_digit ? max_limit : bound_div;
  assign bound_bad  = (bound_src < BOUND_TEN) && (bound_src < digit_s);
  assign bound_prod = PROD_W'(bound_src[INT_BITS-2:0]) * PROD_W'(RECIP10);
  assign bound_quot = $signed({1'b0, bound_prod[RECIP10_SHIFT +: INT_BITS-1]});

  assign int_base = first_digit ? '0 : int_acc;
  assign int_mul  = (MUL_W'(int_base) << 3) + (MUL_W'(int_base) << 1) + MUL_W'(digit);
  assign int_sat  = (int_mul[MUL_W-1:ACC_W] != '0) ? '1 : int_mul[ACC_W-1:0];

  assign frac_mul = (FMUL_W'(facc_eff) << 3) + (FMUL_W'(facc_eff) << 1) + FMUL_W'(digit);

  always_comb begin
    phase_next      = ph_eff;
    negative_next   = neg_eff;
    int_acc_next    = int_acc;
    bound_div_next  = restart ? max_limit : bound_div;
    frac_acc_next   = facc_eff;
    frac_count_next = fcnt_eff;
    emit            = 1'b0;
    fail            = 1'b0;
    case (ph_eff)
      PH_SKIP, PH_SIGNED: begin
        if (ph_eff == PH_SKIP && is_space(ch)) begin
          phase_next = PH_SKIP;
        end else if (ph_eff == PH_SKIP && ch == CH_MINUS) begin
          negative_next = 1'b1;
          phase_next    = PH_SIGNED;
        end else if (!is_digit(ch) || bound_bad) begin
          emit = 1'b1;
          fail = 1'b1;
        end else begin
          int_acc_next   = int_sat;
          bound_div_next = bound_quot;
          phase_next     = PH_INT;
        end
      end
      PH_INT: begin
        if (ch == CH_DOT) begin
          phase_next = PH_DOT;
        end else if (!is_digit(ch) || bound_bad) begin
          emit = 1'b1;
          fail = 1'b1;
        end else begin
          int_acc_next   = int_sat;
          bound_div_next = bound_quot;
        end
      end
      PH_DOT, PH_FRAC: begin
        if (is_digit(ch)) begin
          // digits past the kept count are checked and dropped
          if (fcnt_eff < CNT_W'(MAX_FRAC_DIGITS)) begin
            frac_acc_next   = frac_mul[FRAC_ACC_W-1:0];
            frac_count_next = fcnt_eff + 1'b1;
          end
          phase_next = PH_FRAC;
        end else if (ph_eff == PH_FRAC && (is_space(ch) || ch == CH_COMMA)) begin
          emit = 1'b1;
        end else begin
          emit = 1'b1;
          fail = 1'b1;
        end
      end
      default: begin
        phase_next = ph_eff;
      end
    endcase
    if (emit) begin
      phase_next = PH_DONE;
    end
  end

  assign push                = accept && emit;
  assign push_flags.fail     = fail;
  assign push_flags.negative = neg_eff;
  assign push_int            = int_acc;
  assign push_frac           = facc_eff;
  assign push_count          = fcnt_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SKIP;
      negative   <= 1'b0;
      int_acc    <= '0;
      frac_acc   <= '0;
      frac_count <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      negative   <= negative_next;
      int_acc    <= int_acc_next;
      frac_acc   <= frac_acc_next;
      frac_count <= frac_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bound_div <= bound_div_next;
    end
  end

endmodule

// ===== rtl/adfp_back.sv =====
// conversion back end: fraction scaling divider, range check and output register
`timescale 1ns / 1ps
module adfp_back import adfp_pkg::*; #(
  parameter int FRAC_BITS       = FRAC_BITS_DEF,
  parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF,
  parameter int INT_BITS        = INT_BITS_DEF,
  localparam int ACC_W          = INT_BITS + 1,
  localparam int FRAC_ACC_W     = $clog2(10 ** MAX_FRAC_DIGITS),
  localparam int CNT_W          = $clog2(MAX_FRAC_DIGITS + 1),
  localparam int VALUE_W        = INT_BITS + FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  output logic                       q_pop,
  input  num_flags_t                 q_flags,
  input  logic [ACC_W-1:0]           q_int,
  input  logic [FRAC_ACC_W-1:0]      q_frac,
  input  logic [CNT_W-1:0]           q_count,
  input  logic signed [INT_BITS-1:0] max_limit,
  input  logic signed [INT_BITS-1:0] min_limit,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [VALUE_W-1:0]         out_value,
  output logic                       out_ok
);

  localparam logic B_IDLE = 1'b0;
  localparam logic B_DIV  = 1'b1;

  localparam int DIV_W  = $clog2(10 ** MAX_FRAC_DIGITS + 1);
  localparam int STEP_W = $clog2(FRAC_BITS + 1);
  localparam int CMP_W  = INT_BITS + 2;
  localparam int MAG_W  = ACC_W + FRAC_BITS;

  logic                    bstate;
  logic                    negative;
  logic [ACC_W-1:0]        int_acc;
  logic                    frac_nz;
  logic [DIV_W-1:0]        divisor;
  logic [DIV_W-1:0]        rem;
  logic [FRAC_BITS-1:0]    quot;
  logic [STEP_W-1:0]       step;

  logic                    out_free;
  logic                    div_done;
  logic                    load_out;
  logic [DIV_W:0]          rem_dbl;
  logic                    rem_ge;
  logic [DIV_W:0]          rem_sub;
  logic signed [CMP_W-1:0] lim;
  logic signed [CMP_W-1:0] int_cmp;
  logic                    bad;
  logic [MAG_W-1:0]        mag;
  logic [MAG_W-1:0]        mag_signed;

  assign out_free = !out_valid || out_ready;
  assign div_done = (step == STEP_W'(FRAC_BITS));

  // restoring division, one quotient bit a cycle; remainder stays below the divisor
  assign rem_dbl = {rem, 1'b0};
  assign rem_ge  = (rem_dbl >= {1'b0, divisor});
  assign rem_sub = rem_dbl - {1'b0, divisor};

  assign lim     = negative ? -CMP_W'(min_limit) : CMP_W'(max_limit);
  assign int_cmp = $signed({1'b0, int_acc});
  assign bad     = (lim < 0) || (int_cmp > lim) || ((int_cmp == lim) && frac_nz);

  assign mag        = {int_acc, quot};
  assign mag_signed = negative ? (~mag + 1'b1) : mag;

  assign q_pop = (bstate == B_IDLE) && !q_empty && (!q_flags.fail || out_free);

  // a new result enters the output register
  assign load_out = (bstate == B_IDLE) ? (q_pop && q_flags.fail) : (div_done && out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate    <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (bstate)
        B_IDLE: begin
          if (q_pop && !q_flags.fail) begin
            bstate <= B_DIV;
          end
        end
        B_DIV: begin
          if (div_done && out_free) begin
            bstate <= B_IDLE;
          end
        end
        default: begin
          bstate <= B_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (bstate)
      B_IDLE: begin
        if (q_pop) begin
          negative <= q_flags.negative;
          int_acc  <= q_int;
          frac_nz  <= (q_frac != '0);
          divisor  <= DIV_W'(pow10(4'(q_count)));
          rem      <= DIV_W'(q_frac);
          quot     <= '0;
          step     <= '0;
          if (q_flags.fail) begin
            out_value <= '0;
            out_ok    <= 1'b0;
          end
        end
      end
      B_DIV: begin
        if (!div_done) begin
          rem  <= rem_ge ? rem_sub[DIV_W-1:0] : rem_dbl[DIV_W-1:0];
          quot <= {quot[FRAC_BITS-2:0], rem_ge};
          step <= step + 1'b1;
        end else if (out_free) begin
          out_value <= bad ? '0 : mag_signed[VALUE_W-1:0];
          out_ok    <= !bad;
        end
      end
      default: begin
        step <= '0;
      end
    endcase
  end

endmodule

// ===== rtl/ascii_decimal_to_fixed_parser.sv =====
// top level of the ascii decimal to signed fixed-point parser
`timescale 1ns / 1ps
// Takes the text of one decimal number a byte per request (tdata = character, tuser = restart)
// and returns one fixed-point result per number: tdata = value with FRAC_BITS fraction bits,
// tuser = ok. Leading whitespace and a '-' are allowed; the number needs integer digits, a
// '.', fraction digits and a space or ',' terminator. A bad byte returns value 0 with ok low,
// and later bytes are ignored until a request with restart high. The front end takes one byte
// every cycle while its queue (QUEUE_DEPTH numbers) has room. The back end's restoring divider
// makes one fraction bit per cycle; no new number enters until the last result is loaded, and
// failed numbers skip it. The limit registers are written through cfg_we / cfg_addr /
// cfg_wdata only while no number is in flight: the user must ensure it, the block does not.
module ascii_decimal_to_fixed_parser import adfp_pkg::*; #(
  parameter int FRAC_BITS       = FRAC_BITS_DEF,
  parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF,
  parameter int INT_BITS        = INT_BITS_DEF,
  localparam int VALUE_W        = INT_BITS + FRAC_BITS,
  localparam int OUT_DATA_W     = ((VALUE_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] ch
  input  logic                  s_axis_tuser,   // [0] restart
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [VALUE_W-1:0] value, zero padded
  output logic                  m_axis_tuser,   // [0] ok
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic [INT_BITS-1:0]   cfg_wdata
);

  localparam int ACC_W      = INT_BITS + 1;
  localparam int FRAC_ACC_W = $clog2(10 ** MAX_FRAC_DIGITS);
  localparam int CNT_W      = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int Q_W        = $bits(num_flags_t) + ACC_W + FRAC_ACC_W + CNT_W;

  logic signed [INT_BITS-1:0] max_limit;
  logic signed [INT_BITS-1:0] min_limit;

  logic                  push;
  num_flags_t            push_flags;
  logic [ACC_W-1:0]      push_int;
  logic [FRAC_ACC_W-1:0] push_frac;
  logic [CNT_W-1:0]      push_count;
  logic                  queue_full;
  logic                  queue_empty;
  logic                  q_pop;
  logic [Q_W-1:0]        q_wdata;
  logic [Q_W-1:0]        q_rdata;
  num_flags_t            q_flags;
  logic [ACC_W-1:0]      q_int;
  logic [FRAC_ACC_W-1:0] q_frac;
  logic [CNT_W-1:0]      q_count;
  logic [VALUE_W-1:0]    value;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_limit <= {1'b0, {(INT_BITS-1){1'b1}}};
      min_limit <= {1'b1, {(INT_BITS-1){1'b0}}};
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MAX_LIMIT: max_limit <= cfg_wdata;
        REG_MIN_LIMIT: min_limit <= cfg_wdata;
        default: begin
          max_limit <= max_limit;
        end
      endcase
    end
  end

  adfp_front #(
    .INT_BITS        (INT_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .ch         (s_axis_tdata),
    .restart    (s_axis_tuser),
    .max_limit  (max_limit),
    .queue_full (queue_full),
    .push       (push),
    .push_flags (push_flags),
    .push_int   (push_int),
    .push_frac  (push_frac),
    .push_count (push_count)
  );

  assign q_wdata = {push_flags, push_int, push_frac, push_count};

  adfp_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (q_wdata),
    .full      (queue_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (queue_empty)
  );

  assign {q_flags, q_int, q_frac, q_count} = q_rdata;

  adfp_back #(
    .FRAC_BITS       (FRAC_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS),
    .INT_BITS        (INT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (queue_empty),
    .q_pop     (q_pop),
    .q_flags   (q_flags),
    .q_int     (q_int),
    .q_frac    (q_frac),
    .q_count   (q_count),
    .max_limit (max_limit),
    .min_limit (min_limit),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_value (value),
    .out_ok    (m_axis_tuser)
  );

  assign m_axis_tdata = OUT_DATA_W'(value);

endmodule

// ===== rtl/adfp_checker.sv =====
// port-level checks of the parser, bound to the top level
`timescale 1ns / 1ps
module adfp_checker #(
  parameter int OUT_DATA_W = 40
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tuser
);

  // nothing is left over from before reset
  a_reset_no_result: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result pending right after reset");

  // the queue is empty after reset, so bytes are taken at once
  a_reset_ready: assert property (@(posedge clk) rst |=> s_axis_tready)
    else $error("input not ready right after reset");

  // a failed number always reads as zero
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("failure result with nonzero value");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind ascii_decimal_to_fixed_parser adfp_checker #(
  .OUT_DATA_W (OUT_DATA_W)
) u_adfp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
